>>> rtl/assert_macros.svh
// Assertion macros shared by the level meter RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vlm_pkg.sv
// Package for the voice level meter: config register indexes and level scaling.
// No dependencies; used by the meter top level.
package vlm_pkg;

    // Configuration register indexes
    localparam logic CFG_METER_ENABLE = 1'b0;
    localparam logic CFG_HOLD_TIME    = 1'b1;

    localparam logic [23:0] HOLD_TIME_RESET = 24'd1000000;
    localparam logic [7:0]  LEVEL_FULL      = 8'd128;
    localparam int          LEVEL_MAX_RAW   = 64;

    typedef logic [7:0] t_level;

    // floor(16*sqrt(n)) with bit 0 cleared, n = 0..64
    function automatic t_level level_table(input logic [6:0] n);
        t_level r;
        case (n)
            7'd0:  r = 8'd0;    7'd1:  r = 8'd16;   7'd2:  r = 8'd22;   7'd3:  r = 8'd26;
            7'd4:  r = 8'd32;   7'd5:  r = 8'd34;   7'd6:  r = 8'd38;   7'd7:  r = 8'd42;
            7'd8:  r = 8'd44;   7'd9:  r = 8'd48;   7'd10: r = 8'd50;   7'd11: r = 8'd52;
            7'd12: r = 8'd54;   7'd13: r = 8'd56;   7'd14: r = 8'd58;   7'd15: r = 8'd60;
            7'd16: r = 8'd64;   7'd17: r = 8'd64;   7'd18: r = 8'd66;   7'd19: r = 8'd68;
            7'd20: r = 8'd70;   7'd21: r = 8'd72;   7'd22: r = 8'd74;   7'd23: r = 8'd76;
            7'd24: r = 8'd78;   7'd25: r = 8'd80;   7'd26: r = 8'd80;   7'd27: r = 8'd82;
            7'd28: r = 8'd84;   7'd29: r = 8'd86;   7'd30: r = 8'd86;   7'd31: r = 8'd88;
            7'd32: r = 8'd90;   7'd33: r = 8'd90;   7'd34: r = 8'd92;   7'd35: r = 8'd94;
            7'd36: r = 8'd96;   7'd37: r = 8'd96;   7'd38: r = 8'd98;   7'd39: r = 8'd98;
            7'd40: r = 8'd100;  7'd41: r = 8'd102;  7'd42: r = 8'd102;  7'd43: r = 8'd104;
            7'd44: r = 8'd106;  7'd45: r = 8'd106;  7'd46: r = 8'd108;  7'd47: r = 8'd108;
            7'd48: r = 8'd110;  7'd49: r = 8'd112;  7'd50: r = 8'd112;  7'd51: r = 8'd114;
            7'd52: r = 8'd114;  7'd53: r = 8'd116;  7'd54: r = 8'd116;  7'd55: r = 8'd118;
            7'd56: r = 8'd118;  7'd57: r = 8'd120;  7'd58: r = 8'd120;  7'd59: r = 8'd122;
            7'd60: r = 8'd122;  7'd61: r = 8'd124;  7'd62: r = 8'd124;  7'd63: r = 8'd126;
            7'd64: r = 8'd128;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Channel level: (volume * envelope) >>> 11, clamped, then sqrt-scaled
    function automatic t_level scale_level(input logic signed [7:0] vol,
                                           input logic [10:0] env);
        logic signed [19:0] prod;
        logic signed [7:0]  raw;
        t_level             r;
        prod = vol * $signed({1'b0, env});
        raw  = $signed(prod[18:11]);
        if (raw <= 8'sd0) begin
            r = 8'd0;
        end else if (raw > 8'(LEVEL_MAX_RAW)) begin
            r = LEVEL_FULL;
        end else begin
            r = level_table(raw[6:0]);
        end
        return r;
    endfunction

endpackage

>>> rtl/voice_level_meter_peak_hold_unit.sv
// Voice level meter with peak hold: top level.
// Depends on vlm_pkg and assert_macros.svh.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries one voice update: voice index,
//   left/right volume, envelope and a timestamp. Output channel (o_out_valid /
//   i_out_ready) returns bar heights, held peaks, fade and show flags.
// - Updates for a disabled meter or a voice index not below VOICES are dropped
//   and give no result transaction.
// - Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_index
//   (0 = meter enable, 1 = hold time); write only while the meter is idle.
// - Pipeline: levels are scaled as an accepted input is written to the input
//   register; when the output can advance, per-voice state is read, updated
//   and written back as the result register loads.
// - Throughput: one transaction per cycle unless the output stalls; the per-voice state
//   is written back with the result, so same-voice updates may follow back to back.
// - A stalled output holds its result; the input register still fills behind it,
//   and o_in_ready drops only when both registers are full.
// - Reset (synchronous, active low) clears all per-voice levels, peaks and peak
//   times, enables the meter and sets hold time to 1000000.
module voice_level_meter_peak_hold_unit #(
    parameter int VOICES    = 8,
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [23:0]       i_cfg_wdata,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_voice,
    input  logic signed [7:0] i_left_volume,
    input  logic signed [7:0] i_right_volume,
    input  logic [10:0]       i_envelope,
    input  logic [31:0]       i_now_time,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_voice_out,
    output logic [7:0]        o_left_bar,
    output logic [7:0]        o_right_bar,
    output logic [7:0]        o_left_peak,
    output logic [23:0]       o_left_peak_fade,
    output logic              o_left_peak_show,
    output logic [7:0]        o_right_peak,
    output logic [23:0]       o_right_peak_fade,
    output logic              o_right_peak_show
);

`include "assert_macros.svh"

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CMP_W  = (TIME_BITS > 24) ? TIME_BITS : 24;
    localparam int NCH    = 2;

    // config registers
    logic        r_meter_enable;
    logic [23:0] r_hold_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_enable <= 1'b1;
            r_hold_time    <= vlm_pkg::HOLD_TIME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vlm_pkg::CFG_METER_ENABLE: r_meter_enable <= i_cfg_wdata[0];
                vlm_pkg::CFG_HOLD_TIME:    r_hold_time    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake and pipeline control
    logic r_in_valid;
    logic r_out_valid;
    logic w_adv;
    logic w_fire;
    logic w_in_acc;
    logic w_keep;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_keep     = r_meter_enable && (32'(i_voice) < 32'(VOICES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc && w_keep) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input register: voice, scaled levels and timestamp
    logic [2:0]           r_in_voice;
    logic [7:0]           r_in_level [NCH];
    logic [TIME_BITS-1:0] r_in_now;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_voice    <= i_voice;
            r_in_level[0] <= vlm_pkg::scale_level(i_left_volume, i_envelope);
            r_in_level[1] <= vlm_pkg::scale_level(i_right_volume, i_envelope);
            r_in_now      <= TIME_BITS'(i_now_time);
        end
    end

    logic [4:0]        w_voice_ext;
    logic [VIDX_W-1:0] w_idx;

    assign w_voice_ext = 5'(r_in_voice);
    assign w_idx       = w_voice_ext[VIDX_W-1:0];

    // result register
    logic [2:0]  r_out_voice;
    logic [7:0]  r_out_bar  [NCH];
    logic [7:0]  r_out_peak [NCH];
    logic [23:0] r_out_fade [NCH];
    logic        r_out_show [NCH];

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_voice <= r_in_voice;
        end
    end

    // per-channel state update: smoothing, peak capture and hold aging
    for (genvar ch = 0; ch < NCH; ch++) begin : g_chan
        logic [7:0]           r_last  [VOICES];
        logic [7:0]           r_peak  [VOICES];
        logic [TIME_BITS-1:0] r_ptime [VOICES];

        logic [7:0]           w_prev;
        logic [7:0]           w_pk;
        logic [TIME_BITS-1:0] w_pt;
        logic [8:0]           w_sum;
        logic [7:0]           w_lvl;
        logic                 w_newpk;
        logic [TIME_BITS-1:0] w_age;
        logic [CMP_W-1:0]     w_age_ext;
        logic [CMP_W-1:0]     w_hold_ext;
        logic [CMP_W-1:0]     w_left;
        logic                 w_show;
        logic [7:0]           n_peak;
        logic [TIME_BITS-1:0] n_ptime;

        assign w_prev = r_last[w_idx];
        assign w_pk   = r_peak[w_idx];
        assign w_pt   = r_ptime[w_idx];

        always_comb begin
            // a falling level averages with the last one
            w_sum = 9'(w_prev) + 9'(r_in_level[ch]);
            w_lvl = (r_in_level[ch] < w_prev) ? w_sum[8:1] : r_in_level[ch];
            w_newpk = (w_lvl >= w_pk) && (w_lvl > w_prev);
            // modular age of the held peak
            w_age      = r_in_now - w_pt;
            w_age_ext  = CMP_W'(w_age);
            w_hold_ext = CMP_W'(r_hold_time);
            w_left     = w_hold_ext - w_age_ext;
            w_show     = !w_newpk && (w_pk != 8'd0) && (w_age_ext < w_hold_ext);
            n_peak  = w_newpk ? w_lvl : (w_show ? w_pk : 8'd0);
            n_ptime = w_newpk ? r_in_now : w_pt;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int v = 0; v < VOICES; v++) begin
                    r_last[v]  <= '0;
                    r_peak[v]  <= '0;
                    r_ptime[v] <= '0;
                end
            end else if (w_fire) begin
                r_last[w_idx]  <= w_lvl;
                r_peak[w_idx]  <= n_peak;
                r_ptime[w_idx] <= n_ptime;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_fire) begin
                r_out_bar[ch]  <= w_lvl;
                r_out_peak[ch] <= n_peak;
                r_out_fade[ch] <= w_show ? w_left[23:0] : 24'd0;
                r_out_show[ch] <= w_show;
            end
        end
    end

    // output ports
    assign o_out_valid       = r_out_valid;
    assign o_voice_out       = r_out_voice;
    assign o_left_bar        = r_out_bar[0];
    assign o_right_bar       = r_out_bar[1];
    assign o_left_peak       = r_out_peak[0];
    assign o_right_peak      = r_out_peak[1];
    assign o_left_peak_fade  = r_out_fade[0];
    assign o_right_peak_fade = r_out_fade[1];
    assign o_left_peak_show  = r_out_show[0];
    assign o_right_peak_show = r_out_show[1];

    // checks
    `ASSERT_IMPLY(a_show_has_peak, o_out_valid && (o_left_peak_show || o_right_peak_show), (!o_left_peak_show || o_left_peak != 8'd0) && (!o_right_peak_show || o_right_peak != 8'd0), "shown marker without a held peak")
    `ASSERT_IMPLY(a_fade_matches_show, o_out_valid, ((o_left_peak_fade != 24'd0) == o_left_peak_show) && ((o_right_peak_fade != 24'd0) == o_right_peak_show), "fade and show disagree")
    `ASSERT_IMPLY(a_bar_range, o_out_valid, (o_left_bar <= 8'd128) && (o_right_bar <= 8'd128), "bar height out of range")
    `ASSERT_NEXT(a_drop_no_fill, i_in_valid && o_in_ready && !w_keep && !r_in_valid, !r_in_valid, "dropped transaction entered the pipeline")

endmodule
